// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the point map RTL.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AM_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define AM_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/ppm_pkg.sv =====
// Package for the projective point map: widths, register codes, shared types.
// No dependencies.
`default_nettype none
package ppm_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int COEF_WIDTH  = 64;
	localparam int COORD_FRAC  = 8;
	localparam int COEF_FRAC   = 40;
	localparam int NUM_COEFS   = 8;
	localparam int NUM_PROD    = 6;
	localparam int IDX_W       = $clog2(NUM_COEFS);
	localparam int LO_W        = COEF_WIDTH / 2;
	localparam int HI_W        = COEF_WIDTH - LO_W;
	localparam int PROD_W      = COEF_WIDTH + COORD_WIDTH;
	localparam int SUM_W       = PROD_W + 1;
	localparam int MAG_W       = SUM_W;
	localparam int RW          = MAG_W + COORD_WIDTH;

	localparam logic [COEF_WIDTH-1:0] ONE_COEF = COEF_WIDTH'(64'd1 << COEF_FRAC);

	typedef enum logic [IDX_W-1:0] {
		COEF_A = 3'd0,
		COEF_B = 3'd1,
		COEF_C = 3'd2,
		COEF_D = 3'd3,
		COEF_E = 3'd4,
		COEF_F = 3'd5,
		COEF_G = 3'd6,
		COEF_H = 3'd7
	} coef_idx_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [COEF_WIDTH-1:0]  coef_t;
	typedef logic [MAG_W-1:0]              mag_t;

	typedef struct packed {
		logic zero;
		logic neg_x;
		logic neg_y;
	} ppm_side_t;
endpackage
`default_nettype wire

// ===== rtl/core/ppm_mac.sv =====
// Multiply-accumulate front end: split products, numerator and denominator sums,
// magnitudes and signs over four stages. Depends on ppm_pkg.
`default_nettype none
module ppm_mac import ppm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      v_in,
	input  wire coord_t    x,
	input  wire coord_t    y,
	input  wire coef_t     coef [NUM_COEFS],
	output logic           v_s4,
	output mag_t           nx_mag_s4,
	output mag_t           ny_mag_s4,
	output mag_t           d_mag_s4,
	output ppm_side_t      side_s4
);
	logic signed [LO_W+COORD_WIDTH:0]   pl_s1 [NUM_PROD];
	logic signed [HI_W+COORD_WIDTH-1:0] ph_s1 [NUM_PROD];
	logic signed [PROD_W-1:0]           prod_s2 [NUM_PROD];
	logic signed [SUM_W-1:0]            nx_s3, ny_s3, d_s3;
	logic v_s1, v_s2, v_s3;

	for (genvar j = 0; j < NUM_PROD; j++) begin : g_prod
		localparam int CI = (j < 2) ? j : ((j < 4) ? j + 1 : j + 2);
		coef_t  cw;
		coord_t cd;
		assign cw = coef[CI];
		assign cd = (j % 2 == 0) ? x : y;
		always_ff @(posedge clk) begin
			if (en) begin
				pl_s1[j]   <= $signed({1'b0, cw[LO_W-1:0]}) * cd;
				ph_s1[j]   <= $signed(cw[COEF_WIDTH-1:LO_W]) * cd;
				prod_s2[j] <= (PROD_W'(ph_s1[j]) <<< LO_W) + PROD_W'(pl_s1[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3 <= SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1])
				+ (SUM_W'(coef[COEF_C]) <<< COORD_FRAC);
			ny_s3 <= SUM_W'(prod_s2[2]) + SUM_W'(prod_s2[3])
				+ (SUM_W'(coef[COEF_F]) <<< COORD_FRAC);
			d_s3  <= SUM_W'(prod_s2[4]) + SUM_W'(prod_s2[5])
				+ (SUM_W'($signed(ONE_COEF)) <<< COORD_FRAC);
			nx_mag_s4     <= nx_s3[SUM_W-1] ? mag_t'(-nx_s3) : mag_t'(nx_s3);
			ny_mag_s4     <= ny_s3[SUM_W-1] ? mag_t'(-ny_s3) : mag_t'(ny_s3);
			d_mag_s4      <= d_s3[SUM_W-1] ? mag_t'(-d_s3) : mag_t'(d_s3);
			side_s4.zero  <= (d_s3 == '0);
			side_s4.neg_x <= nx_s3[SUM_W-1] ^ d_s3[SUM_W-1];
			side_s4.neg_y <= ny_s3[SUM_W-1] ^ d_s3[SUM_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/ppm_div.sv =====
// Pipelined restoring divider for both coordinates sharing one divisor:
// one range check stage, then one quotient bit per stage. Depends on ppm_pkg.
`default_nettype none
module ppm_div import ppm_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_in,
	input  wire mag_t            nx_mag,
	input  wire mag_t            ny_mag,
	input  wire mag_t            d_mag,
	input  wire ppm_side_t       side_in,
	output logic                 v_out,
	output logic [COORD_WIDTH-1:0] qx,
	output logic [COORD_WIDTH-1:0] qy,
	output logic                 ovf_x,
	output logic                 ovf_y,
	output ppm_side_t            side_out
);
	logic [RW-1:0]          rem_x_s [COORD_WIDTH+1];
	logic [RW-1:0]          rem_y_s [COORD_WIDTH+1];
	logic [RW-1:0]          den_s   [COORD_WIDTH+1];
	logic [COORD_WIDTH-1:0] q_x_s   [COORD_WIDTH+1];
	logic [COORD_WIDTH-1:0] q_y_s   [COORD_WIDTH+1];
	logic                   ovf_x_s [COORD_WIDTH+1];
	logic                   ovf_y_s [COORD_WIDTH+1];
	ppm_side_t              side_s  [COORD_WIDTH+1];
	logic                   v_s     [COORD_WIDTH+1];

	logic [RW-1:0] nx_w, ny_w, dtop_w;
	assign nx_w   = RW'(nx_mag) << COORD_FRAC;
	assign ny_w   = RW'(ny_mag) << COORD_FRAC;
	assign dtop_w = RW'(d_mag) << COORD_WIDTH;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_x_s[0] <= nx_w;
			rem_y_s[0] <= ny_w;
			den_s[0]   <= RW'(d_mag);
			q_x_s[0]   <= '0;
			q_y_s[0]   <= '0;
			ovf_x_s[0] <= (nx_w >= dtop_w);
			ovf_y_s[0] <= (ny_w >= dtop_w);
			side_s[0]  <= side_in;
		end
	end

	for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_bit
		localparam int B = COORD_WIDTH - 1 - k;
		logic [RW-1:0] trial;
		logic          ge_x, ge_y;
		assign trial = den_s[k] << B;
		assign ge_x  = (rem_x_s[k] >= trial);
		assign ge_y  = (rem_y_s[k] >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_x_s[k+1] <= ge_x ? rem_x_s[k] - trial : rem_x_s[k];
				rem_y_s[k+1] <= ge_y ? rem_y_s[k] - trial : rem_y_s[k];
				den_s[k+1]   <= den_s[k];
				q_x_s[k+1]   <= {q_x_s[k][COORD_WIDTH-2:0], ge_x};
				q_y_s[k+1]   <= {q_y_s[k][COORD_WIDTH-2:0], ge_y};
				ovf_x_s[k+1] <= ovf_x_s[k];
				ovf_y_s[k+1] <= ovf_y_s[k];
				side_s[k+1]  <= side_s[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_in;
		end
	end

	assign v_out    = v_s[COORD_WIDTH];
	assign qx       = q_x_s[COORD_WIDTH];
	assign qy       = q_y_s[COORD_WIDTH];
	assign ovf_x    = ovf_x_s[COORD_WIDTH];
	assign ovf_y    = ovf_y_s[COORD_WIDTH];
	assign side_out = side_s[COORD_WIDTH];
endmodule
`default_nettype wire

// ===== rtl/core/projective_point_map_unit.sv =====
// Stages from request accept to out_valid: 4 multiply/sum stages, 1 range check,
// 32 quotient bit stages, output register. Throughput: one point per cycle while
// in_stall is low; the quotient pipeline retires one bit per stage.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset clears valid bits and loads the identity coefficient set.
// Top level of the projective point map; depends on ppm_pkg, ppm_mac, ppm_div, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module projective_point_map_unit import ppm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire coef_t            cfg_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire coord_t           in_x,
	input  wire coord_t           in_y,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output coord_t                out_x,
	output coord_t                out_y,
	output logic                  zero_denominator,
	output logic                  saturated
);
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   zd;
		logic   sat;
	} result_t;

	coef_t     coef_q [NUM_COEFS];
	logic      en;
	logic      v_mac;
	mag_t      nx_mag, ny_mag, d_mag;
	ppm_side_t side_mac, side_div;
	logic      v_div, ovf_x, ovf_y;
	logic [COORD_WIDTH-1:0] qx, qy;
	result_t   res, out_q, skid_q;
	logic      out_valid_q, skid_valid_q;
	logic      sat_x, sat_y;
	coord_t    val_x, val_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[COEF_A] <= ONE_COEF;
			coef_q[COEF_E] <= ONE_COEF;
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	ppm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (in_valid),
		.x        (in_x),
		.y        (in_y),
		.coef     (coef_q),
		.v_s4     (v_mac),
		.nx_mag_s4(nx_mag),
		.ny_mag_s4(ny_mag),
		.d_mag_s4 (d_mag),
		.side_s4  (side_mac)
	);

	ppm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_mac),
		.nx_mag  (nx_mag),
		.ny_mag  (ny_mag),
		.d_mag   (d_mag),
		.side_in (side_mac),
		.v_out   (v_div),
		.qx      (qx),
		.qy      (qy),
		.ovf_x   (ovf_x),
		.ovf_y   (ovf_y),
		.side_out(side_div)
	);

	function automatic logic sat_of(input logic [COORD_WIDTH-1:0] q, input logic ovf,
		input logic neg);
		if (neg) begin
			return ovf || (q[COORD_WIDTH-1] && (q[COORD_WIDTH-2:0] != '0));
		end
		return ovf || q[COORD_WIDTH-1];
	endfunction

	function automatic coord_t val_of(input logic [COORD_WIDTH-1:0] q, input logic sat,
		input logic neg);
		if (sat) begin
			return neg ? coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}})
			           : coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
		end
		return neg ? coord_t'(~q + 1'b1) : coord_t'(q);
	endfunction

	always_comb begin
		sat_x = sat_of(qx, ovf_x, side_div.neg_x);
		sat_y = sat_of(qy, ovf_y, side_div.neg_y);
		val_x = val_of(qx, sat_x, side_div.neg_x);
		val_y = val_of(qy, sat_y, side_div.neg_y);
		if (side_div.zero) begin
			res = '{x: '0, y: '0, zd: 1'b1, sat: 1'b0};
		end else begin
			res = '{x: val_x, y: val_y, zd: 1'b0, sat: sat_x || sat_y};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= v_div;
			end
		end else if (v_div && en) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (v_div && en) begin
			skid_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_x            = out_q.x;
	assign out_y            = out_q.y;
	assign zero_denominator = out_q.zd;
	assign saturated        = out_q.sat;

	`AM_IMPLY(a_skid_behind_out, skid_valid_q, out_valid_q)
	`AM_IMPLY(a_zero_den_clean, out_valid_q && out_q.zd,
		!out_q.sat && out_q.x == '0 && out_q.y == '0)
	`AM_NEXT(a_cfg_write_a, cfg_we && cfg_index == COEF_A,
		coef_q[COEF_A] == $past(cfg_data))
endmodule
`default_nettype wire
